FILE: hdl/fds_pkg.sv
// Shared types and constants for the FAT32 directory entry search block.
package fds_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_FOUND     = 2'd0,
    STAT_END       = 2'd1,
    STAT_EXHAUSTED = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_NAME_LOW  = 2'd0,
    CFG_NAME_HIGH = 2'd1,
    CFG_DIR_ONLY  = 2'd2
  } cfg_index_t;

  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned NameLowW   = 64;
  localparam int unsigned NameHighW  = 24;
  localparam int unsigned NameBytes  = 11;

  // Directory entry byte values
  localparam logic [7:0] BYTE_END_MARK = 8'h00;
  localparam logic [7:0] BYTE_DELETED  = 8'hE5;
  localparam logic [7:0] ATTR_LFN      = 8'h0F;
  localparam int unsigned AttrDirBit   = 4;    // attribute bit 0x10

  // Byte positions inside a 32-byte entry
  typedef logic [4:0] offset_t;
  localparam offset_t OFF_FIRST    = 5'd0;
  localparam offset_t OFF_ATTR     = 5'd11;
  localparam offset_t OFF_CLUS_HI0 = 5'd20;
  localparam offset_t OFF_CLUS_HI1 = 5'd21;
  localparam offset_t OFF_CLUS_LO0 = 5'd26;
  localparam offset_t OFF_CLUS_LO1 = 5'd27;
  localparam offset_t OFF_SIZE0    = 5'd28;
  localparam offset_t OFF_LAST     = 5'd31;

endpackage

FILE: hdl/fds_if.sv
// Valid/ready channel interfaces for directory bytes and search results.
interface fds_in_if
  import fds_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  logic       last_byte;

  modport source (output valid, output data_byte, output restart, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input restart, input last_byte,
                  output ready);
endinterface

interface fds_out_if
  import fds_pkg::*;
();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] first_cluster;
  logic [31:0] entry_size;

  modport source (output valid, output status, output first_cluster, output entry_size,
                  input ready);
  modport sink   (input valid, input status, input first_cluster, input entry_size,
                  output ready);
endinterface

FILE: hdl/fat32_directory_entry_search.sv
// FAT32 directory entry search: byte-stream scan of 32-byte short-name entries.
//
//  Channel   Dir  Payload                               Handshake
//  in_chan   in   data_byte[8], restart, last_byte      valid/ready
//  out_chan  out  status[2], first_cluster[32],
//                 entry_size[32]                        valid/ready
//  cfg_*     in   cfg_index[2], cfg_wdata[64]           cfg_we, no wait
//
// One byte is taken per cycle while in_chan.ready is high; each transfer updates the entry
// state in the same cycle and a result appears in the output register in the cycle after.
// While a result waits in the output register and out_chan.ready is low,
// in_chan.ready is low for every byte, including bytes that would be ignored.
// Reset (synchronous, rst_n low) clears the scan state, the configuration registers and the output valid flag.
module fat32_directory_entry_search
  import fds_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  fds_in_if.sink              in_chan,
  fds_out_if.source           out_chan,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // Configuration registers
  logic [NameLowW-1:0]  name_low_r;
  logic [NameHighW-1:0] name_high_r;
  logic                 dir_only_r;

  // Scan state
  offset_t     offset_r,   offset_nxt;
  logic        name_ok_r,  name_ok_nxt;
  logic        skip_r,     skip_nxt;
  logic        is_dir_r,   is_dir_nxt;
  logic [15:0] clus_hi_r,  clus_hi_nxt;
  logic [15:0] clus_lo_r,  clus_lo_nxt;
  logic [31:0] size_r,     size_nxt;
  logic        done_r,     done_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  status_t     status_r,    status_nxt;
  logic [31:0] cluster_r,   cluster_nxt;
  logic [31:0] esize_r,     esize_nxt;

  logic        in_xfer;
  logic        emit;
  logic [7:0]  b;
  offset_t     off;
  logic        done_eff;
  logic [7:0]  name_bytes [NameBytes];
  logic [3:0]  name_idx;
  logic        want_match;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign b             = in_chan.data_byte;

  // Target name as a byte array
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      name_bytes[i] = name_low_r[i*8 +: 8];
    end
    for (int i = 0; i < 3; i++) begin
      name_bytes[8+i] = name_high_r[i*8 +: 8];
    end
  end

  // Restart rewinds the offset and reopens the scan on this same byte
  assign off      = in_chan.restart ? OFF_FIRST : offset_r;
  assign done_eff = in_chan.restart ? 1'b0 : done_r;
  assign name_idx = (off < offset_t'(NameBytes)) ? off[3:0] : 4'd0;

  // Per-byte entry processing
  always_comb begin
    offset_nxt    = offset_r;
    name_ok_nxt   = name_ok_r;
    skip_nxt      = skip_r;
    is_dir_nxt    = is_dir_r;
    clus_hi_nxt   = clus_hi_r;
    clus_lo_nxt   = clus_lo_r;
    size_nxt      = size_r;
    done_nxt      = done_r;
    emit          = 1'b0;
    status_nxt    = STAT_EXHAUSTED;
    cluster_nxt   = '0;
    esize_nxt     = '0;
    want_match    = 1'b0;

    if (in_xfer) begin
      offset_nxt = off;
      done_nxt   = done_eff;
      if (!done_eff) begin
        if (off == OFF_FIRST && b == BYTE_END_MARK) begin
          // End-of-directory marker
          emit       = 1'b1;
          status_nxt = STAT_END;
          done_nxt   = 1'b1;
        end else begin
          if (off == OFF_FIRST) begin
            skip_nxt    = (b == BYTE_DELETED);
            name_ok_nxt = 1'b1;
          end
          if (off < offset_t'(NameBytes)) begin
            if (b != name_bytes[name_idx]) begin
              name_ok_nxt = 1'b0;
            end
          end else if (off == OFF_ATTR) begin
            if (b == ATTR_LFN) begin
              skip_nxt = 1'b1;
            end
            is_dir_nxt = b[AttrDirBit];
          end else if (off == OFF_CLUS_HI0) begin
            clus_hi_nxt[7:0] = b;
          end else if (off == OFF_CLUS_HI1) begin
            clus_hi_nxt[15:8] = b;
          end else if (off == OFF_CLUS_LO0) begin
            clus_lo_nxt[7:0] = b;
          end else if (off == OFF_CLUS_LO1) begin
            clus_lo_nxt[15:8] = b;
          end else if (off >= OFF_SIZE0) begin
            size_nxt[off[1:0]*8 +: 8] = b;
          end

          offset_nxt = off + 5'd1;
          want_match = (is_dir_nxt == dir_only_r);

          // Report a match when an entry completes, else stop at the end of data on any byte
          if (off == OFF_LAST && !skip_nxt && name_ok_nxt && want_match) begin
            emit        = 1'b1;
            status_nxt  = STAT_FOUND;
            cluster_nxt = {clus_hi_nxt, clus_lo_nxt};
            esize_nxt   = size_nxt;
            done_nxt    = 1'b1;
          end else if (in_chan.last_byte) begin
            emit       = 1'b1;
            status_nxt = STAT_EXHAUSTED;
            done_nxt   = 1'b1;
          end
        end
      end
    end
  end

  // Output slot: filled by a result, freed by a transfer
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_low_r  <= '0;
      name_high_r <= '0;
      dir_only_r  <= 1'b0;
      offset_r    <= OFF_FIRST;
      name_ok_r   <= 1'b1;
      skip_r      <= 1'b0;
      is_dir_r    <= 1'b0;
      clus_hi_r   <= '0;
      clus_lo_r   <= '0;
      size_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      offset_r    <= offset_nxt;
      name_ok_r   <= name_ok_nxt;
      skip_r      <= skip_nxt;
      is_dir_r    <= is_dir_nxt;
      clus_hi_r   <= clus_hi_nxt;
      clus_lo_r   <= clus_lo_nxt;
      size_r      <= size_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_NAME_LOW:  name_low_r  <= cfg_wdata[NameLowW-1:0];
          CFG_NAME_HIGH: name_high_r <= cfg_wdata[NameHighW-1:0];
          CFG_DIR_ONLY:  dir_only_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      status_r  <= status_nxt;
      cluster_r <= cluster_nxt;
      esize_r   <= esize_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = status_r;
  assign out_chan.first_cluster = cluster_r;
  assign out_chan.entry_size    = esize_r;

endmodule
